>>> rtl/skprs_pkg.sv
// Package for the sorted key prefix range search unit.
// Holds table sizes, function codes, FSM state type and key/index helpers.
// No dependencies.
package skprs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_CHARS   = 8;
  localparam int KEY_BITS    = 8 * KEY_CHARS;

  // Fixed field widths
  localparam int KEY_W     = 64;
  localparam int FUNC_W    = 2;
  localparam int PLEN_W    = 4;
  localparam int OUT_IDX_W = 8;

  // Derived widths: index into the table, and a count that can hold the depth
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OUT_IDX_W-1:0] out_idx_t;
  typedef logic [FUNC_W-1:0]    func_t;
  typedef logic [PLEN_W-1:0]    plen_t;

  // Function codes
  localparam func_t FUNC_APPEND = 2'd0;
  localparam func_t FUNC_QUERY  = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_LO,
    ST_VERIFY,
    ST_SRCH_HI,
    ST_RESULT
  } state_t;

  // Bits that belong to a stored key
  function automatic key_t key_mask();
    key_t m;
    for (int i = 0; i < KEY_W; i++) begin
      m[i] = (i < KEY_BITS);
    end
    return m;
  endfunction

  // Keeps the first plen characters (clamped to KEY_CHARS), first char is the top byte
  function automatic key_t prefix_mask(plen_t plen);
    key_t m;
    int   n;
    m = '0;
    n = (int'(plen) > KEY_CHARS) ? KEY_CHARS : int'(plen);
    for (int c = 0; c < KEY_CHARS; c++) begin
      if (c < n) begin
        m[8*(KEY_CHARS-1-c) +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Midpoint of [lo, hi); always below the depth while lo < hi
  function automatic idx_t mid_of(cnt_t lo, cnt_t hi);
    logic [CNT_W:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    return s[IDX_W:1];
  endfunction

  // Low bits of an index as reported on the result
  function automatic out_idx_t out_idx(cnt_t v);
    logic [CNT_W+OUT_IDX_W-1:0] e;
    e = {{OUT_IDX_W{1'b0}}, v};
    return e[OUT_IDX_W-1:0];
  endfunction

endpackage

>>> rtl/skprs_req_if.sv
// Request channel of the search unit: function, key/prefix and prefix length.
// Depends on skprs_pkg.
interface skprs_req_if import skprs_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  key_t  key_chars;
  plen_t prefix_len;

  modport source (output valid, func, key_chars, prefix_len, input ready);
  modport sink   (input valid, func, key_chars, prefix_len, output ready);
endinterface

>>> rtl/skprs_rsp_if.sv
// Response channel of the search unit: hit flag, index range and full flag.
// Depends on skprs_pkg.
interface skprs_rsp_if import skprs_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     found;
  out_idx_t first_index;
  out_idx_t last_index;
  logic     table_full;

  modport source (output valid, found, first_index, last_index, table_full, input ready);
  modport sink   (input valid, found, first_index, last_index, table_full, output ready);
endinterface

>>> rtl/skprs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skprs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/sorted_key_prefix_range_search_unit.sv
// Sorted key prefix range search unit, top level.
// Append/clear/unused codes skip the search and go straight to the result state.
// Query: a binary search for the first match and, on a hit, one for the last, each of up to
// log2(depth)+1 probes, one per cycle on the key RAM read port.
// One transaction in flight; the next request is taken once the result is queued.
// Synchronous reset empties the table (entry count 0); key RAM contents are not cleared.
module sorted_key_prefix_range_search_unit import skprs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  skprs_req_if.sink    req,
  skprs_rsp_if.source  rsp
);

  state_t   state, state_next;
  cnt_t     entry_count;
  cnt_t     lo, lo_next, hi, hi_next;
  cnt_t     res, res_next;
  logic     res_valid, res_valid_next;
  cnt_t     first;
  logic     found;
  logic     full;
  key_t     pm, pre;

  logic     accept;
  logic     wr_en;
  idx_t     rd_addr;
  key_t     rd_data;
  idx_t     mid;
  cnt_t     mid_p1;
  logic     match, key_lt, hit;
  logic     out_free;

  logic     out_valid, out_found, out_full;
  out_idx_t out_first, out_last;

  // Key table
  skprs_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (req.key_chars & key_mask()),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // Probe compare against the registered prefix
  assign mid    = mid_of(lo, hi);
  assign mid_p1 = CNT_W'(mid) + CNT_W'(1);
  assign match  = ((rd_data & pm) == pre);
  assign key_lt = (rd_data < pre);
  assign hit    = (lo < entry_count) && match;

  // Search bounds
  always_comb begin
    lo_next        = lo;
    hi_next        = hi;
    res_next       = res;
    res_valid_next = res_valid;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          lo_next        = '0;
          hi_next        = entry_count;
          res_next       = '0;
          res_valid_next = 1'b0;
        end
      end
      ST_SRCH_LO: begin
        if (lo < hi) begin
          if (!match && key_lt) lo_next = mid_p1;
          else                  hi_next = CNT_W'(mid);
        end
      end
      ST_VERIFY: begin
        lo_next = '0;
        hi_next = entry_count;
      end
      ST_SRCH_HI: begin
        if (lo < hi) begin
          if (match) begin
            res_next       = CNT_W'(mid);
            res_valid_next = 1'b1;
          end
          if (match || key_lt) lo_next = mid_p1;
          else                 hi_next = CNT_W'(mid);
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = (req.func == FUNC_QUERY) ? ST_SRCH_LO : ST_RESULT;
      end
      ST_SRCH_LO: state_next = (lo_next < hi_next) ? ST_SRCH_LO : ST_VERIFY;
      ST_VERIFY:  state_next = hit ? ST_SRCH_HI : ST_RESULT;
      ST_SRCH_HI: state_next = (lo_next < hi_next) ? ST_SRCH_HI : ST_RESULT;
      ST_RESULT:  state_next = out_free ? ST_IDLE : ST_RESULT;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake, RAM write and read address
  always_comb begin
    req.ready = (state == ST_IDLE);
    wr_en     = accept && (req.func == FUNC_APPEND) &&
                (entry_count < CNT_W'(TABLE_DEPTH));
    // Read for the next cycle: the candidate index after the first search, else the midpoint
    if (state == ST_SRCH_LO && state_next == ST_VERIFY) rd_addr = lo_next[IDX_W-1:0];
    else                                                rd_addr = mid_of(lo_next, hi_next);
  end

  // Control registers: state, entry count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (req.func == FUNC_APPEND && entry_count < CNT_W'(TABLE_DEPTH)) begin
          entry_count <= entry_count + CNT_W'(1);
        end else if (req.func == FUNC_CLEAR) begin
          entry_count <= '0;
        end
      end
      if (state == ST_RESULT && out_free) out_valid <= 1'b1;
      else if (rsp.ready)                 out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    res       <= res_next;
    res_valid <= res_valid_next;
    if (accept) begin
      pm    <= prefix_mask(req.prefix_len);
      pre   <= req.key_chars & key_mask() & prefix_mask(req.prefix_len);
      found <= 1'b0;
      first <= '0;
      full  <= (req.func == FUNC_APPEND) && (entry_count >= CNT_W'(TABLE_DEPTH));
    end
    if (state == ST_VERIFY) begin
      found <= hit;
      first <= hit ? lo : '0;
    end
    if (state == ST_RESULT && out_free) begin
      out_found <= found;
      out_first <= out_idx(first);
      out_last  <= found ? out_idx(res_valid ? res : first) : '0;
      out_full  <= full;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.first_index = out_first;
  assign rsp.last_index  = out_last;
  assign rsp.table_full  = out_full;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_bounds_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_LO || state == ST_SRCH_HI) |-> (lo <= hi && hi <= entry_count))
    else $error("search bounds out of range");

  a_count_held: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> $stable(entry_count))
    else $error("table changed during a transaction");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESULT)
    else $error("result raised outside result state");

endmodule
